// ===== rtl/bgc_pkg.sv =====
// Shared constants, command codes and sequencer states for the bipartite check.
`timescale 1ns / 1ps
package bgc_pkg;

  localparam int unsigned DefMaxNodes = 2048;
  localparam int unsigned DefMaxEdges = 4096;

  // Fixed field widths of the request and result items
  localparam int unsigned IdW    = 11;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_START  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_EREAD,
    S_EWAIT,
    S_FIND,
    S_FWAIT,
    S_DONE
  } state_e;

endpackage

// ===== rtl/bgc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bgc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bipartite_graph_check.sv =====
// Top level: edge store plus a union-find walker with parity that decides bipartiteness.
//
// Start and add-edge requests are accepted while idle; a valid edge is written into the
// edge RAM in the cycle it is accepted. A finish request first sweeps the parent RAM, one
// node per cycle (nodes 0 through the node count), then walks the stored edges one at a
// time: S_EREAD and S_EWAIT fetch an edge, then S_FIND and S_FWAIT visit each node on the
// way to the root of each end (one read port on the parent RAM); the link or parity
// compare happens in the S_FWAIT that reaches the second root. Without path compression
// a root search can visit every node. The verdict is then held in an output register
// until taken; start and add-edge requests are still accepted while it waits, a new
// finish is not.
`timescale 1ns / 1ps
module bipartite_graph_check #(
  parameter int unsigned MAX_NODES = bgc_pkg::DefMaxNodes,
  parameter int unsigned MAX_EDGES = bgc_pkg::DefMaxEdges
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] command, [12:2] node_count, [23:13] first_node, [34:24] second_node
  input  logic [bgc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] not_bipartite, [1] input_error
  output logic [bgc_pkg::OutDataW-1:0] m_axis_tdata
);
  import bgc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);

  // Request fields
  logic [CmdW-1:0] cmd;
  logic [IdW-1:0]  cnt_in, a_in, b_in;
  assign cmd    = s_axis_tdata[1:0];
  assign cnt_in = s_axis_tdata[12:2];
  assign a_in   = s_axis_tdata[23:13];
  assign b_in   = s_axis_tdata[34:24];

  state_e state_q, state_d;
  logic [IdW-1:0] nodes_q;
  logic [CW-1:0]  etot_q, eidx_q, eidx_d;
  logic           err_q, clash_q, clash_d;
  logic           oval_q, oval_d, onb_q, oerr_q;
  logic [NW-1:0]  cur_q, cur_d, bnode_q, bnode_d, roota_q, roota_d, sweep_q, sweep_d;
  logic           par_q, par_d, para_q, para_d, side_q, side_d;

  logic acc, add_ok;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign add_ok = (a_in != '0) && (b_in != '0) && (a_in <= nodes_q) && (b_in <= nodes_q)
                  && (32'(etot_q) < MAX_EDGES);

  // Edge RAM: written on accepted valid add, read during the walk
  logic [2*NW-1:0] edata;
  bgc_ram #(.Width(2*NW), .Depth(MAX_EDGES)) u_edges (
    .clk_i   (clk_i),
    .we_i    (acc && (cmd == CMD_ADD) && add_ok),
    .waddr_i (etot_q[AW-1:0]),
    .wdata_i ({NW'(b_in), NW'(a_in)}),
    .raddr_i (eidx_q[AW-1:0]),
    .rdata_o (edata)
  );

  // Parent RAM: {parity to parent, parent id}
  logic          pwe;
  logic [NW-1:0] pwaddr;
  logic [NW:0]   pwdata, pdata;
  bgc_ram #(.Width(NW+1), .Depth(MAX_NODES)) u_parent (
    .clk_i   (clk_i),
    .we_i    (pwe),
    .waddr_i (pwaddr),
    .wdata_i (pwdata),
    .raddr_i (cur_q),
    .rdata_o (pdata)
  );

  logic is_root;
  assign is_root = (pdata[NW-1:0] == cur_q);

  // Ready: idle, and a finish waits until the last verdict is taken
  assign s_axis_tready = (state_q == S_IDLE) && (!oval_q || (cmd != CMD_FINISH));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (acc && (cmd == CMD_FINISH)) state_d = S_INIT;
      S_INIT:  if (sweep_q == NW'(nodes_q)) state_d = S_EREAD;
      S_EREAD: state_d = (eidx_q == etot_q) ? S_DONE : S_EWAIT;
      S_EWAIT: state_d = S_FIND;
      S_FIND:  state_d = S_FWAIT;
      S_FWAIT: state_d = (is_root && side_q) ? S_EREAD : S_FIND;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    eidx_d  = eidx_q;
    clash_d = clash_q;
    cur_d   = cur_q;
    bnode_d = bnode_q;
    roota_d = roota_q;
    sweep_d = sweep_q;
    par_d   = par_q;
    para_d  = para_q;
    side_d  = side_q;
    oval_d  = oval_q && !m_axis_tready;
    pwe     = 1'b0;
    pwaddr  = sweep_q;
    pwdata  = {1'b0, sweep_q};
    unique case (state_q)
      S_IDLE: begin
        sweep_d = '0;
        eidx_d  = '0;
        clash_d = 1'b0;
      end
      S_INIT: begin
        pwe     = 1'b1;
        sweep_d = sweep_q + 1'b1;
      end
      S_EWAIT: begin
        cur_d   = edata[NW-1:0];
        bnode_d = edata[2*NW-1:NW];
        par_d   = 1'b0;
        side_d  = 1'b0;
      end
      S_FWAIT: begin
        if (!is_root) begin
          cur_d = pdata[NW-1:0];
          par_d = par_q ^ pdata[NW];
        end else if (!side_q) begin
          roota_d = cur_q;
          para_d  = par_q;
          cur_d   = bnode_q;
          par_d   = 1'b0;
          side_d  = 1'b1;
        end else begin
          eidx_d = eidx_q + 1'b1;
          if (cur_q == roota_q) begin
            clash_d = clash_q || (par_q == para_q);
          end else begin
            pwe    = 1'b1;
            pwaddr = roota_q;
            pwdata = {~(para_q ^ par_q), cur_q};
          end
        end
      end
      S_DONE: oval_d = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nodes_q <= '0;
      etot_q  <= '0;
      err_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
      if (acc && (cmd == CMD_START)) begin
        nodes_q <= ((MAX_NODES - 1 < 2047) && (32'(cnt_in) > MAX_NODES - 1)) ?
                   IdW'(MAX_NODES - 1) : cnt_in;
        etot_q  <= '0;
        err_q   <= 1'b0;
      end else if (acc && (cmd == CMD_ADD)) begin
        if (add_ok) etot_q <= etot_q + 1'b1;
        else        err_q  <= 1'b1;
      end
    end
  end

  // Walk and result payload registers
  always_ff @(posedge clk_i) begin
    eidx_q  <= eidx_d;
    clash_q <= clash_d;
    cur_q   <= cur_d;
    bnode_q <= bnode_d;
    roota_q <= roota_d;
    sweep_q <= sweep_d;
    par_q   <= par_d;
    para_q  <= para_d;
    side_q  <= side_d;
    if (state_q == S_DONE) begin
      onb_q  <= clash_q;
      oerr_q <= err_q;
    end
  end

  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = {6'b0, oerr_q, onb_q};

endmodule

// ===== rtl/bgc_checker.sv =====
// Port-level checks for the bipartite check, bound to the top level.
`timescale 1ns / 1ps
module bgc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [bgc_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bgc_pkg::OutDataW-1:0] m_axis_tdata
);
  import bgc_pkg::*;

  // A held verdict keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict changed while stalled");

  // A finish request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == CMD_FINISH) |=> !s_axis_tready)
    else $error("ready after finish");

  // One verdict per finish: no second result right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("repeated verdict");

  // Unused result bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'b0))
    else $error("padding bits set");

endmodule

bind bipartite_graph_check bgc_checker u_bgc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
